// File: rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and letter helpers for the Playfair digraph
// decryptor: command codes, cell control word, byte cleaning, row/column split.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = 25;
    localparam int ALPHA = 26;

    localparam logic [4:0]  LETTER_I = 5'd8;
    localparam logic [4:0]  LETTER_J = 5'd9;
    localparam logic [6:0]  ASCII_A  = 7'h41;
    localparam logic [25:0] J_MASK   = 26'd1 << LETTER_J;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_KEY    = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_CIPHER = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       clr;
        logic       wr_en;
        logic [4:0] wr_letter;
        logic [4:0] qa;
        logic [4:0] qb;
    } cell_ctl_t;

    // {is_letter, index}; J folds onto I
    function automatic logic [5:0] clean_byte(input logic [7:0] b);
        logic [7:0] diff;
        logic       ok;
        logic [4:0] idx;
        diff = 8'd0;
        ok   = 1'b0;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            diff = b - 8'h41;
            ok   = 1'b1;
        end
        else if (b >= 8'h61 && b <= 8'h7A)
        begin
            diff = b - 8'h61;
            ok   = 1'b1;
        end
        idx = diff[4:0];
        if (idx == LETTER_J)
        begin
            idx = LETTER_I;
        end
        return {ok, idx};
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] pos);
        logic [2:0] r;
        priority if (pos >= 5'd20) r = 3'd4;
        else if (pos >= 5'd15)     r = 3'd3;
        else if (pos >= 5'd10)     r = 3'd2;
        else if (pos >= 5'd5)      r = 3'd1;
        else                       r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] pos);
        logic [4:0] base;
        logic [4:0] diff;
        base = {2'b00, pos_row(pos)};
        diff = pos - ((base << 2) + base);
        return diff[2:0];
    endfunction

    // step back one place around the square
    function automatic logic [2:0] wrap_dec(input logic [2:0] v);
        return (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
    endfunction

    function automatic logic [4:0] make_pos(input logic [2:0] r, input logic [2:0] c);
        logic [4:0] rr;
        rr = {2'b00, r};
        return (rr << 2) + rr + {2'b00, c};
    endfunction

endpackage

// File: rtl/pfd_ram.sv
// ----------------------------------------------------------------------------
// pfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfd_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/pfd_cell.sv
// ----------------------------------------------------------------------------
// pfd_cell
// One square of the key: holds its letter and the fill token, takes the
// token from its left neighbor on each append, and answers position lookups.
// ----------------------------------------------------------------------------
module pfd_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  pfd_pkg::cell_ctl_t ctl,
    input  logic [4:0]        cell_pos,
    input  logic              tok_in,
    output logic              tok_out,
    output logic [4:0]        rd_a,
    output logic [4:0]        rd_b
);

    logic       tok_reg;
    logic       tok_next;
    logic [4:0] letter_reg;

    always_comb
    begin
        tok_next = tok_reg;
        if (ctl.clr)
        begin
            tok_next = 1'b0;
        end
        else if (ctl.wr_en)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && tok_in)
        begin
            letter_reg <= ctl.wr_letter;
        end
    end

    assign tok_out = tok_reg;
    assign rd_a    = (cell_pos == ctl.qa) ? letter_reg : 5'd0;
    assign rd_b    = (cell_pos == ctl.qb) ? letter_reg : 5'd0;

endmodule

// File: rtl/playfair_digraph_decryptor.sv
// ----------------------------------------------------------------------------
// playfair_digraph_decryptor
// Builds a 5x5 Playfair key square in a chain of cells and decrypts cipher
// letters in pairs.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------
//   cmd     | cmd_valid / cmd_stall  | command, data_byte
//   plain   | plain_valid / plain_stall | plain_letter, last
//
// Clear, keyword byte and unpaired cipher letter: handled in idle, no stall.
// Finish fill: one letter of the alphabet per cycle.
// Cipher pair: two reads of the position RAM, one target compute and one
// cell lookup, then two output words.
// Reset is asynchronous; the key square and position RAM are not cleared.
// plain_stall holds the current output word; cmd_stall is high while busy.
// ----------------------------------------------------------------------------
module playfair_digraph_decryptor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       plain_valid,
    input  logic       plain_stall,
    output logic [6:0] plain_letter,
    output logic       last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_RD1,
        S_RD2,
        S_CALC,
        S_LOOK,
        S_OUT0,
        S_OUT1
    } state_t;

    state_t      state_reg, state_next;
    logic [25:0] used_reg, used_next;
    logic [4:0]  fill_reg, fill_next;
    logic [4:0]  scan_reg, scan_next;
    logic [4:0]  pend_reg, pend_next;
    logic        pend_ok_reg, pend_ok_next;
    logic [4:0]  cur_reg, cur_next;
    logic [4:0]  p1_reg, p1_next;
    logic [4:0]  qa_reg, qa_next;
    logic [4:0]  qb_reg, qb_next;
    logic [4:0]  a_reg, a_next;
    logic [4:0]  b_reg, b_next;

    logic        acc;
    logic [5:0]  cl;
    logic        app_try;
    logic        app_do;
    logic [4:0]  app_letter;
    logic        clr;
    logic [4:0]  ram_addr;
    logic [4:0]  ram_q;
    logic [2:0]  r1, c1, r2, c2;
    logic [4:0]  rd_a_or, rd_b_or;

    pfd_pkg::cell_ctl_t ctl;
    logic [pfd_pkg::CELLS-1:0] tok_vec;
    logic [4:0] rd_a_vec [pfd_pkg::CELLS];
    logic [4:0] rd_b_vec [pfd_pkg::CELLS];

    assign acc = cmd_valid && !cmd_stall;
    assign cl  = pfd_pkg::clean_byte(data_byte);

    assign r1 = pfd_pkg::pos_row(p1_reg);
    assign c1 = pfd_pkg::pos_col(p1_reg);
    assign r2 = pfd_pkg::pos_row(ram_q);
    assign c2 = pfd_pkg::pos_col(ram_q);

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        fill_next    = fill_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        pend_ok_next = pend_ok_reg;
        cur_next     = cur_reg;
        p1_next      = p1_reg;
        qa_next      = qa_reg;
        qb_next      = qb_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        app_try      = 1'b0;
        app_letter   = cl[4:0];
        clr          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (pfd_pkg::cmd_t'(command))
                        pfd_pkg::CMD_CLEAR:
                        begin
                            used_next    = pfd_pkg::J_MASK;
                            fill_next    = 5'd0;
                            pend_ok_next = 1'b0;
                            clr          = 1'b1;
                        end
                        pfd_pkg::CMD_KEY:
                        begin
                            app_try = cl[5];
                        end
                        pfd_pkg::CMD_FILL:
                        begin
                            scan_next  = 5'd0;
                            state_next = S_FILL;
                        end
                        pfd_pkg::CMD_CIPHER:
                        begin
                            if (cl[5])
                            begin
                                if (!pend_ok_reg)
                                begin
                                    pend_next    = cl[4:0];
                                    pend_ok_next = 1'b1;
                                end
                                else
                                begin
                                    cur_next     = cl[4:0];
                                    pend_ok_next = 1'b0;
                                    state_next   = S_RD1;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                app_try    = 1'b1;
                app_letter = scan_reg;
                scan_next  = scan_reg + 5'd1;
                if (scan_reg == 5'(pfd_pkg::ALPHA - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD1:
            begin
                state_next = S_RD2;
            end
            S_RD2:
            begin
                p1_next    = ram_q;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                priority if (r1 == r2)
                begin
                    qa_next = pfd_pkg::make_pos(r1, pfd_pkg::wrap_dec(c1));
                    qb_next = pfd_pkg::make_pos(r2, pfd_pkg::wrap_dec(c2));
                end
                else if (c1 == c2)
                begin
                    qa_next = pfd_pkg::make_pos(pfd_pkg::wrap_dec(r1), c1);
                    qb_next = pfd_pkg::make_pos(pfd_pkg::wrap_dec(r2), c2);
                end
                else
                begin
                    qa_next = pfd_pkg::make_pos(r1, c2);
                    qb_next = pfd_pkg::make_pos(r2, c1);
                end
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                a_next     = rd_a_or;
                b_next     = rd_b_or;
                state_next = S_OUT0;
            end
            S_OUT0:
            begin
                if (!plain_stall)
                begin
                    state_next = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (!plain_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        app_do = app_try && !used_reg[app_letter] && (fill_reg != 5'(pfd_pkg::CELLS));
        if (app_do)
        begin
            used_next[app_letter] = 1'b1;
            fill_next             = fill_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= pfd_pkg::J_MASK;
            fill_reg    <= 5'd0;
            scan_reg    <= 5'd0;
            pend_reg    <= 5'd0;
            pend_ok_reg <= 1'b0;
            cur_reg     <= 5'd0;
            p1_reg      <= 5'd0;
            qa_reg      <= 5'd0;
            qb_reg      <= 5'd0;
            a_reg       <= 5'd0;
            b_reg       <= 5'd0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            fill_reg    <= fill_next;
            scan_reg    <= scan_next;
            pend_reg    <= pend_next;
            pend_ok_reg <= pend_ok_next;
            cur_reg     <= cur_next;
            p1_reg      <= p1_next;
            qa_reg      <= qa_next;
            qb_reg      <= qb_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
        end
    end

    assign ram_addr = (state_reg == S_RD1) ? pend_reg : cur_reg;

    pfd_ram #(
        .WIDTH (5),
        .DEPTH (pfd_pkg::ALPHA)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (app_do),
        .wr_addr (app_letter),
        .wr_data (fill_reg),
        .rd_addr (ram_addr),
        .rd_data (ram_q)
    );

    assign ctl.clr       = clr;
    assign ctl.wr_en     = app_do;
    assign ctl.wr_letter = app_letter;
    assign ctl.qa        = qa_reg;
    assign ctl.qb        = qb_reg;

    for (genvar k = 0; k < pfd_pkg::CELLS; k++)
    begin : g_cell
        logic tok_in;
        if (k == 0)
        begin : g_head
            assign tok_in = (fill_reg == 5'd0);
        end
        else
        begin : g_link
            assign tok_in = tok_vec[k-1];
        end
        pfd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .cell_pos (5'(k)),
            .tok_in   (tok_in),
            .tok_out  (tok_vec[k]),
            .rd_a     (rd_a_vec[k]),
            .rd_b     (rd_b_vec[k])
        );
    end

    always_comb
    begin
        rd_a_or = 5'd0;
        rd_b_or = 5'd0;
        for (int k = 0; k < pfd_pkg::CELLS; k++)
        begin
            rd_a_or = rd_a_or | rd_a_vec[k];
            rd_b_or = rd_b_or | rd_b_vec[k];
        end
    end

    assign cmd_stall    = (state_reg != S_IDLE);
    assign plain_valid  = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign last         = (state_reg == S_OUT1);
    assign plain_letter = pfd_pkg::ASCII_A +
                          {2'b00, ((state_reg == S_OUT1) ? b_reg : a_reg)};

    a_tok_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_vec) == ((fill_reg != 5'd0) ? 1 : 0))
        else $error("fill token out of step with fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'(pfd_pkg::CELLS))
        else $error("fill count past end of square");

    a_j_used: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg[pfd_pkg::LETTER_J])
        else $error("J left unmarked");

    a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
        plain_valid && last && !plain_stall |=> !plain_valid)
        else $error("output word after end of pair");

    a_busy_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD1) |-> !pend_ok_reg)
        else $error("held letter kept while decrypting pair");

endmodule
